/* rtl/core/scpt_pkg.sv */
// Shared constants, register codes and word types of the segment pair connect test.
package scpt_pkg;

  localparam int COORD_BITS     = 14;
  localparam int FRAC_BITS_DEF  = 4;
  localparam int UNIT_BITS      = 24;
  localparam int DIST_BITS      = 16;
  localparam int WIDTH_BITS     = 16;
  localparam int GAP_BITS       = 14;
  localparam int VERDICT_BITS   = 3;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_PLANE_DISTANCE = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_GAP            = 1'd1;

  localparam logic [WIDTH_BITS-1:0] MAX_PLANE_DISTANCE_RESET = 16'd32;
  localparam logic [GAP_BITS-1:0]   MAX_GAP_RESET            = 14'd10;

  localparam logic [VERDICT_BITS-1:0] VERDICT_OVERLAP    = 3'd0;
  localparam logic [VERDICT_BITS-1:0] VERDICT_WITHIN_GAP = 3'd1;
  localparam logic [VERDICT_BITS-1:0] VERDICT_TOO_FAR    = 3'd2;
  localparam logic [VERDICT_BITS-1:0] VERDICT_GAP_LARGE  = 3'd3;
  localparam logic [VERDICT_BITS-1:0] VERDICT_DEGENERATE = 3'd4;

  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] first_start_x;
    logic [COORD_BITS-1:0] first_start_y;
    logic [COORD_BITS-1:0] first_end_x;
    logic [COORD_BITS-1:0] first_end_y;
    logic [WIDTH_BITS-1:0] first_width;
    logic [COORD_BITS-1:0] second_start_x;
    logic [COORD_BITS-1:0] second_start_y;
    logic [COORD_BITS-1:0] second_end_x;
    logic [COORD_BITS-1:0] second_end_y;
    logic [WIDTH_BITS-1:0] second_width;
  } seg_word_t;

  typedef struct packed {
    logic                    joinable;
    logic [VERDICT_BITS-1:0] verdict;
    logic [DIST_BITS-1:0]    line_distance;
  } res_word_t;

endpackage

/* rtl/core/segment_pair_connect_test_top.sv */
// Top level of the segment pair connect test pipeline.
// Throughput: one word per cycle while not stalled; latency is set mostly by the two 25-stage root chains.
// Stall freezes the pipeline only when its last stage holds a word the output cannot take.
// Reset clears all valid bits and loads max_plane_distance 32 and max_gap 10.
module segment_pair_connect_test_top
  import scpt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      seg_valid,
  output logic                      seg_stall,
  input  seg_word_t                 seg_word,
  output logic                      res_valid,
  input  logic                      res_stall,
  output res_word_t                 res_word,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int C      = COORD_BITS;
  localparam int U      = UNIT_BITS;
  localparam int D_W    = C + 1;
  localparam int L_W    = 2 * C + 1;
  localparam int CR_W   = 2 * D_W + 1;
  localparam int X_W    = 2 * C + 2;
  localparam int LIM2_W = 2 * WIDTH_BITS;
  localparam int DS_W   = 2 * X_W + 2 * FRAC_BITS;
  localparam int FP_W   = LIM2_W + L_W;
  localparam int CMP_W  = (DS_W > FP_W) ? DS_W : FP_W;
  localparam int UC_W   = 2 * C;
  localparam int US_W   = UC_W + 2 * U;
  localparam int UM_W   = U + 1;
  localparam int SUM_W  = U + 3;
  localparam int SM_W   = U + 2;
  localparam int SQ_W   = 2 * SM_W;
  localparam int LS_W   = SQ_W + 1;
  localparam int BS_W   = SQ_W + 2 * U;
  localparam int W_W    = U + 2;
  localparam int P_W    = W_W + C + 2;

  typedef struct packed {
    logic                deg;
    logic                far;
    logic [3:0]          sgn;
    logic [7:0][C-1:0]   pts;
  } sb_a_t;

  typedef struct packed {
    sb_a_t                a;
    logic [DIST_BITS-1:0] max_dist;
  } sb_b_t;

  typedef struct packed {
    sb_b_t      b;
    logic [1:0] wsgn;
  } sb_c_t;

  logic en;

  logic [WIDTH_BITS-1:0] max_plane_distance;
  logic [GAP_BITS-1:0]   max_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_plane_distance <= MAX_PLANE_DISTANCE_RESET;
      max_gap            <= MAX_GAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_PLANE_DISTANCE: begin
          max_plane_distance <= cfg_data[WIDTH_BITS-1:0];
        end
        REG_MAX_GAP: begin
          max_gap <= cfg_data[GAP_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  logic v1, v2, v3, v4, v5, v6, v7, v8;

  // stage 1: input register and limit select
  seg_word_t             s1_word;
  logic [WIDTH_BITS-1:0] s1_lim;
  logic [WIDTH_BITS-1:0] lim_c;

  assign lim_c = seg_word.mode ?
                 ((seg_word.first_width > seg_word.second_width) ?
                  seg_word.first_width : seg_word.second_width) :
                 max_plane_distance;

  // stage 2: differences
  logic signed [D_W-1:0] s2_dx [4];
  logic signed [D_W-1:0] s2_qx [4];
  logic signed [D_W-1:0] s2_qy [4];
  logic [7:0][C-1:0]     s2_pts;
  logic [WIDTH_BITS-1:0] s2_lim;
  logic signed [D_W-1:0] dx_c [4];
  logic signed [D_W-1:0] qx_c [4];
  logic signed [D_W-1:0] qy_c [4];
  logic [7:0][C-1:0]     pts_c;

  always_comb begin
    pts_c[0] = s1_word.first_start_x;
    pts_c[1] = s1_word.first_start_y;
    pts_c[2] = s1_word.first_end_x;
    pts_c[3] = s1_word.first_end_y;
    pts_c[4] = s1_word.second_start_x;
    pts_c[5] = s1_word.second_start_y;
    pts_c[6] = s1_word.second_end_x;
    pts_c[7] = s1_word.second_end_y;
    dx_c[0] = $signed({1'b0, pts_c[2]}) - $signed({1'b0, pts_c[0]});
    dx_c[1] = $signed({1'b0, pts_c[3]}) - $signed({1'b0, pts_c[1]});
    dx_c[2] = $signed({1'b0, pts_c[6]}) - $signed({1'b0, pts_c[4]});
    dx_c[3] = $signed({1'b0, pts_c[7]}) - $signed({1'b0, pts_c[5]});
    // segment a against b start and end, segment b against a start and end
    qx_c[0] = $signed({1'b0, pts_c[4]}) - $signed({1'b0, pts_c[0]});
    qy_c[0] = $signed({1'b0, pts_c[5]}) - $signed({1'b0, pts_c[1]});
    qx_c[1] = $signed({1'b0, pts_c[6]}) - $signed({1'b0, pts_c[0]});
    qy_c[1] = $signed({1'b0, pts_c[7]}) - $signed({1'b0, pts_c[1]});
    qx_c[2] = $signed({1'b0, pts_c[0]}) - $signed({1'b0, pts_c[4]});
    qy_c[2] = $signed({1'b0, pts_c[1]}) - $signed({1'b0, pts_c[5]});
    qx_c[3] = $signed({1'b0, pts_c[2]}) - $signed({1'b0, pts_c[4]});
    qy_c[3] = $signed({1'b0, pts_c[3]}) - $signed({1'b0, pts_c[5]});
  end

  // stage 3: squares, cross products, dot product, squared limit
  logic [L_W-1:0]         s3_la;
  logic [L_W-1:0]         s3_lb;
  logic signed [CR_W-1:0] s3_cr [4];
  logic signed [D_W-1:0]  s3_dx [4];
  logic                   s3_flip;
  logic [LIM2_W-1:0]      s3_lim2;
  logic [7:0][C-1:0]      s3_pts;
  logic signed [CR_W-1:0] cr_c [4];
  logic signed [L_W:0]    la_c;
  logic signed [L_W:0]    lb_c;
  logic signed [2*D_W:0]  dot_c;

  always_comb begin
    logic signed [D_W-1:0] sdx;
    logic signed [D_W-1:0] sdy;
    for (int i = 0; i < 4; i++) begin
      sdx = (i < 2) ? s2_dx[0] : s2_dx[2];
      sdy = (i < 2) ? s2_dx[1] : s2_dx[3];
      cr_c[i] = sdx * s2_qy[i] - sdy * s2_qx[i];
    end
    la_c  = s2_dx[0] * s2_dx[0] + s2_dx[1] * s2_dx[1];
    lb_c  = s2_dx[2] * s2_dx[2] + s2_dx[3] * s2_dx[3];
    dot_c = s2_dx[0] * s2_dx[2] + s2_dx[1] * s2_dx[3];
  end

  // stage 4: squared distances, limit products, unit vector squares
  logic [DS_W-1:0] s4_ds [4];
  logic [FP_W-1:0] s4_fp [2];
  logic [UC_W-1:0] s4_uc2 [4];
  logic [L_W-1:0]  s4_la;
  logic [L_W-1:0]  s4_lb;
  logic [3:0]      s4_sgn;
  logic            s4_deg;
  logic [7:0][C-1:0] s4_pts;
  logic [DS_W-1:0] ds_c [4];
  logic [FP_W-1:0] fp_c [2];
  logic [UC_W-1:0] uc2_c [4];
  logic [3:0]      sgn_c;

  always_comb begin
    logic [X_W-1:0]   xm;
    logic [2*X_W-1:0] xx;
    logic [C-1:0]     um;
    for (int i = 0; i < 4; i++) begin
      xm = X_W'(s3_cr[i][CR_W-1] ? -s3_cr[i] : s3_cr[i]);
      xx = xm * xm;
      ds_c[i] = {xx, {(2 * FRAC_BITS){1'b0}}};
      um = C'(s3_dx[i][D_W-1] ? -s3_dx[i] : s3_dx[i]);
      uc2_c[i] = um * um;
    end
    fp_c[0] = s3_lim2 * s3_la;
    fp_c[1] = s3_lim2 * s3_lb;
    sgn_c[0] = s3_dx[0][D_W-1];
    sgn_c[1] = s3_dx[1][D_W-1];
    sgn_c[2] = s3_dx[2][D_W-1] ^ s3_flip;
    sgn_c[3] = s3_dx[3][D_W-1] ^ s3_flip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= seg_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_word <= seg_word;
      s1_lim  <= lim_c;
      s2_dx   <= dx_c;
      s2_qx   <= qx_c;
      s2_qy   <= qy_c;
      s2_pts  <= pts_c;
      s2_lim  <= s1_lim;
      s3_la   <= L_W'(la_c);
      s3_lb   <= L_W'(lb_c);
      s3_cr   <= cr_c;
      s3_dx   <= s2_dx;
      s3_flip <= dot_c[2*D_W];
      s3_lim2 <= s2_lim * s2_lim;
      s3_pts  <= s2_pts;
      s4_ds   <= ds_c;
      s4_fp   <= fp_c;
      s4_uc2  <= uc2_c;
      s4_la   <= s3_la;
      s4_lb   <= s3_lb;
      s4_sgn  <= sgn_c;
      s4_deg  <= (s3_la == '0) || (s3_lb == '0);
      s4_pts  <= s3_pts;
    end
  end

  // root pipelines for endpoint distances and unit direction vectors
  sb_a_t sb1_in;
  sb_a_t sb1_out;
  logic  sb1_valid;
  logic [DIST_BITS-1:0] dm [4];
  logic [UM_W-1:0]      um_r [4];

  assign sb1_in.deg = s4_deg;
  assign sb1_in.far = (CMP_W'(s4_ds[0]) > CMP_W'(s4_fp[0])) ||
                      (CMP_W'(s4_ds[1]) > CMP_W'(s4_fp[0])) ||
                      (CMP_W'(s4_ds[2]) > CMP_W'(s4_fp[1])) ||
                      (CMP_W'(s4_ds[3]) > CMP_W'(s4_fp[1]));
  assign sb1_in.sgn = s4_sgn;
  assign sb1_in.pts = s4_pts;

  for (genvar k = 0; k < 4; k++) begin : g_roots
    scpt_root #(
      .NB  (DIST_BITS),
      .S_W (DS_W),
      .L_W (L_W)
    ) u_dist_root (
      .clk (clk),
      .en  (en),
      .s   (s4_ds[k]),
      .l   ((k < 2) ? s4_la : s4_lb),
      .m   (dm[k])
    );

    scpt_root #(
      .NB  (UM_W),
      .S_W (US_W),
      .L_W (L_W)
    ) u_unit_root (
      .clk (clk),
      .en  (en),
      .s   ({s4_uc2[k], {(2 * U){1'b0}}}),
      .l   ((k < 2) ? s4_la : s4_lb),
      .m   (um_r[k])
    );
  end

  scpt_delay #(
    .W     ($bits(sb_a_t)),
    .DEPTH (DIST_BITS)
  ) u_sb1 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_data   (sb1_in),
    .out_valid (sb1_valid),
    .out_data  (sb1_out)
  );

  sb_b_t sb2_in;
  sb_b_t sb2_out;
  logic  sb2_valid;
  logic [DIST_BITS-1:0] dmax01;
  logic [DIST_BITS-1:0] dmax23;

  assign dmax01          = (dm[0] > dm[1]) ? dm[0] : dm[1];
  assign dmax23          = (dm[2] > dm[3]) ? dm[2] : dm[3];
  assign sb2_in.a        = sb1_out;
  assign sb2_in.max_dist = (dmax01 > dmax23) ? dmax01 : dmax23;

  scpt_delay #(
    .W     ($bits(sb_b_t)),
    .DEPTH (UM_W - DIST_BITS)
  ) u_sb2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sb1_valid),
    .in_data   (sb2_in),
    .out_valid (sb2_valid),
    .out_data  (sb2_out)
  );

  // stage 5: signed unit vectors and their sum
  logic signed [SUM_W-1:0] s5_sx;
  logic signed [SUM_W-1:0] s5_sy;
  sb_b_t                   s5_sb;
  logic signed [SUM_W-1:0] u_c [4];

  always_comb begin
    logic signed [SUM_W-1:0] mag;
    for (int i = 0; i < 4; i++) begin
      mag    = $signed(SUM_W'(um_r[i]));
      u_c[i] = sb2_out.a.sgn[i] ? -mag : mag;
    end
  end

  // stage 6: bisector squares
  logic [SQ_W-1:0] s6_sq [2];
  logic [LS_W-1:0] s6_ls;
  logic [1:0]      s6_wsgn;
  sb_b_t           s6_sb;
  logic [SM_W-1:0] sxm_c;
  logic [SM_W-1:0] sym_c;
  logic [SQ_W-1:0] sqx_c;
  logic [SQ_W-1:0] sqy_c;

  assign sxm_c = SM_W'(s5_sx[SUM_W-1] ? -s5_sx : s5_sx);
  assign sym_c = SM_W'(s5_sy[SUM_W-1] ? -s5_sy : s5_sy);
  assign sqx_c = sxm_c * sxm_c;
  assign sqy_c = sym_c * sym_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v5 <= sb2_valid;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sx   <= u_c[0] + u_c[2];
      s5_sy   <= u_c[1] + u_c[3];
      s5_sb   <= sb2_out;
      s6_sq[0] <= sqx_c;
      s6_sq[1] <= sqy_c;
      s6_ls   <= LS_W'(sqx_c) + LS_W'(sqy_c);
      s6_wsgn <= {s5_sy[SUM_W-1], s5_sx[SUM_W-1]};
      s6_sb   <= s5_sb;
    end
  end

  // bisector normalization
  logic [UM_W-1:0] wm [2];
  sb_c_t           sb3_in;
  sb_c_t           sb3_out;
  logic            sb3_valid;

  for (genvar k = 0; k < 2; k++) begin : g_bis
    scpt_root #(
      .NB  (UM_W),
      .S_W (BS_W),
      .L_W (LS_W)
    ) u_bis_root (
      .clk (clk),
      .en  (en),
      .s   ({s6_sq[k], {(2 * U){1'b0}}}),
      .l   (s6_ls),
      .m   (wm[k])
    );
  end

  assign sb3_in.b    = s6_sb;
  assign sb3_in.wsgn = s6_wsgn;

  scpt_delay #(
    .W     ($bits(sb_c_t)),
    .DEPTH (UM_W)
  ) u_sb3 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .in_data   (sb3_in),
    .out_valid (sb3_valid),
    .out_data  (sb3_out)
  );

  // stage 7: projections onto the bisector
  logic signed [P_W-1:0] s7_pr [4];
  sb_b_t                 s7_sb;
  logic signed [P_W-1:0] pr_c [4];

  always_comb begin
    logic signed [W_W-1:0] wx;
    logic signed [W_W-1:0] wy;
    logic signed [C:0]     cx;
    logic signed [C:0]     cy;
    wx = sb3_out.wsgn[0] ? -$signed(W_W'(wm[0])) : $signed(W_W'(wm[0]));
    wy = sb3_out.wsgn[1] ? -$signed(W_W'(wm[1])) : $signed(W_W'(wm[1]));
    for (int i = 0; i < 4; i++) begin
      cx      = $signed({1'b0, sb3_out.b.a.pts[2*i]});
      cy      = $signed({1'b0, sb3_out.b.a.pts[2*i+1]});
      pr_c[i] = wx * cx + wy * cy;
    end
  end

  // stage 8: interval ends
  logic signed [P_W-1:0] s8_alo;
  logic signed [P_W-1:0] s8_ahi;
  logic signed [P_W-1:0] s8_blo;
  logic signed [P_W-1:0] s8_bhi;
  sb_b_t                 s8_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v7 <= sb3_valid;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_pr  <= pr_c;
      s7_sb  <= sb3_out.b;
      s8_alo <= (s7_pr[0] > s7_pr[1]) ? s7_pr[1] : s7_pr[0];
      s8_ahi <= (s7_pr[0] > s7_pr[1]) ? s7_pr[0] : s7_pr[1];
      s8_blo <= (s7_pr[2] > s7_pr[3]) ? s7_pr[3] : s7_pr[2];
      s8_bhi <= (s7_pr[2] > s7_pr[3]) ? s7_pr[2] : s7_pr[3];
      s8_sb  <= s7_sb;
    end
  end

  // gap test and verdict
  res_word_t             res_c;
  logic signed [P_W-1:0] gap_c;
  logic                  overlap_c;
  logic [P_W-1:0]        gap_lim;

  assign gap_lim = P_W'({max_gap, {U{1'b0}}});

  always_comb begin
    overlap_c = 1'b0;
    if (s8_blo > s8_ahi) begin
      gap_c = s8_blo - s8_ahi;
    end else if (s8_bhi < s8_alo) begin
      gap_c = s8_alo - s8_bhi;
    end else begin
      gap_c     = '0;
      overlap_c = 1'b1;
    end
    res_c.line_distance = s8_sb.max_dist;
    if (s8_sb.a.deg) begin
      res_c.joinable      = 1'b0;
      res_c.verdict       = VERDICT_DEGENERATE;
      res_c.line_distance = '0;
    end else if (s8_sb.a.far) begin
      res_c.joinable = 1'b0;
      res_c.verdict  = VERDICT_TOO_FAR;
    end else if (overlap_c) begin
      res_c.joinable = 1'b1;
      res_c.verdict  = VERDICT_OVERLAP;
    end else if ($unsigned(gap_c) <= gap_lim) begin
      res_c.joinable = 1'b1;
      res_c.verdict  = VERDICT_WITHIN_GAP;
    end else begin
      res_c.joinable = 1'b0;
      res_c.verdict  = VERDICT_GAP_LARGE;
    end
  end

  // hold the pipeline only when its last stage has a word and the output is blocked
  assign en        = !(res_valid && res_stall && v8);
  assign seg_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      res_word <= res_c;
    end
  end

endmodule

/* rtl/core/scpt_root.sv */
// Pipelined bit-serial root ratio: largest m with m*m*l <= s, one bit per stage.
module scpt_root #(
  parameter int NB  = 16,
  parameter int S_W = 64,
  parameter int L_W = 29
) (
  input  logic           clk,
  input  logic           en,
  input  logic [S_W-1:0] s,
  input  logic [L_W-1:0] l,
  output logic [NB-1:0]  m
);

  localparam int XW = ((S_W > 2 * NB + L_W) ? S_W : 2 * NB + L_W) + 2;
  localparam int PW = NB + L_W;

  logic [XW-1:0]  e_st [NB];
  logic [PW-1:0]  p_st [NB];
  logic [NB-1:0]  m_st [NB];
  logic [L_W-1:0] l_st [NB];

  for (genvar j = 0; j < NB; j++) begin : g_step
    localparam int B = NB - 1 - j;
    logic [XW-1:0]  e_in;
    logic [XW-1:0]  t;
    logic [PW-1:0]  p_in;
    logic [NB-1:0]  m_in;
    logic [L_W-1:0] l_in;
    logic           take;

    if (j == 0) begin : g_first
      assign e_in = XW'(s);
      assign p_in = '0;
      assign m_in = '0;
      assign l_in = l;
    end else begin : g_next
      assign e_in = e_st[j-1];
      assign p_in = p_st[j-1];
      assign m_in = m_st[j-1];
      assign l_in = l_st[j-1];
    end

    assign t    = (XW'(p_in) << (B + 1)) + (XW'(l_in) << (2 * B));
    assign take = (t <= e_in);

    always_ff @(posedge clk) begin
      if (en) begin
        l_st[j] <= l_in;
        if (take) begin
          e_st[j] <= e_in - t;
          p_st[j] <= p_in + (PW'(l_in) << B);
          m_st[j] <= m_in | (NB'(1) << B);
        end else begin
          e_st[j] <= e_in;
          p_st[j] <= p_in;
          m_st[j] <= m_in;
        end
      end
    end
  end

  assign m = m_st[NB-1];

endmodule

/* rtl/core/scpt_delay.sv */
// Delay line for side data with a valid bit per stage.
module scpt_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic [DEPTH-1:0] valid;
  logic [W-1:0]     data [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        data[i] <= data[i-1];
      end
    end
  end

  assign out_valid = valid[DEPTH-1];
  assign out_data  = data[DEPTH-1];

endmodule

/* tb/segment_pair_connect_test_top_test.sv */
// Testbench for the segment pair connect test: directed and random pairs against a predictor.
`timescale 1ns / 1ps

module segment_pair_connect_test_top_test;
  import scpt_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seg_valid = 1'b0;
  logic seg_stall;
  seg_word_t seg_word = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_word_t res_word;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MAX_PLANE_DISTANCE;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  res_word_t verdicts_due[$];
  logic [15:0] plane_limit;
  logic [13:0] gap_limit;
  int fails = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  segment_pair_connect_test_top uut (
    .clk(clk), .rst(rst),
    .seg_valid(seg_valid), .seg_stall(seg_stall), .seg_word(seg_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit prod_fits(logic [63:0] a, logic [63:0] b,
                                   logic [63:0] c, logic [63:0] d);
    logic [127:0] p;
    logic [127:0] q;
    p = 128'(a) * 128'(b);
    q = 128'(c) * 128'(d);
    return p <= q;
  endfunction

  function automatic logic [63:0] floor_ratio(logic [63:0] r, logic [63:0] len2,
                                              logic [63:0] cap, int nbits);
    logic [63:0] m;
    logic [63:0] cand;
    m = 0;
    for (int b = nbits - 1; b >= 0; b--) begin
      cand = m | (64'd1 << b);
      if (cand <= cap && prod_fits(cand * cand, len2, r, r)) m = cand;
    end
    return m;
  endfunction

  function automatic longint unit_part(longint comp, logic [63:0] len2);
    longint m;
    logic [63:0] mg;
    mg = comp < 0 ? -comp : comp;
    m = floor_ratio(mg << UNIT_BITS, len2, 64'd1 << UNIT_BITS, UNIT_BITS + 1);
    return comp < 0 ? -m : m;
  endfunction

  function automatic res_word_t judge_pair(seg_word_t w);
    res_word_t o;
    longint a[4];
    longint b[4];
    longint dxa, dya, dxb, dyb, ua0, ua1, ub0, ub1, sx, sy, wx, wy;
    longint ta0, ta1, tb0, tb1, tmp, gap, cr, px, py;
    logic [63:0] la, lb, lim, worst, len2, r, d, ls;
    bit far;
    a = '{longint'(w.first_start_x), longint'(w.first_start_y),
          longint'(w.first_end_x), longint'(w.first_end_y)};
    b = '{longint'(w.second_start_x), longint'(w.second_start_y),
          longint'(w.second_end_x), longint'(w.second_end_y)};
    dxa = a[2] - a[0]; dya = a[3] - a[1];
    dxb = b[2] - b[0]; dyb = b[3] - b[1];
    la = dxa * dxa + dya * dya;
    lb = dxb * dxb + dyb * dyb;
    o = '0;
    if (la == 0 || lb == 0) begin
      o.verdict = VERDICT_DEGENERATE;
      return o;
    end
    if (w.mode) lim = w.first_width > w.second_width ? w.first_width : w.second_width;
    else lim = plane_limit;
    worst = 0;
    far = 1'b0;
    for (int i = 0; i < 4; i++) begin
      px = (i < 2) ? b[(i & 1) * 2] : a[(i & 1) * 2];
      py = (i < 2) ? b[(i & 1) * 2 + 1] : a[(i & 1) * 2 + 1];
      if (i < 2) begin
        cr = dxa * (py - a[1]) - dya * (px - a[0]);
        len2 = la;
      end else begin
        cr = dxb * (py - b[1]) - dyb * (px - b[0]);
        len2 = lb;
      end
      r = (cr < 0 ? -cr : cr) << FRAC_BITS_DEF;
      d = floor_ratio(r, len2, 64'd65535, 16);
      if (d > worst) worst = d;
      if (prod_fits(lim * lim, len2, r, r) && !prod_fits(r, r, lim * lim, len2)) far = 1'b1;
    end
    o.line_distance = worst[15:0];
    if (far) begin
      o.verdict = VERDICT_TOO_FAR;
      return o;
    end
    if (dxa * dxb + dya * dyb < 0) begin
      dxb = -dxb; dyb = -dyb;
    end
    ua0 = unit_part(dxa, la); ua1 = unit_part(dya, la);
    ub0 = unit_part(dxb, lb); ub1 = unit_part(dyb, lb);
    sx = ua0 + ub0; sy = ua1 + ub1;
    ls = sx * sx + sy * sy;
    wx = unit_part(sx, ls); wy = unit_part(sy, ls);
    ta0 = wx * a[0] + wy * a[1]; ta1 = wx * a[2] + wy * a[3];
    tb0 = wx * b[0] + wy * b[1]; tb1 = wx * b[2] + wy * b[3];
    if (ta0 > ta1) begin tmp = ta0; ta0 = ta1; ta1 = tmp; end
    if (tb0 > tb1) begin tmp = tb0; tb0 = tb1; tb1 = tmp; end
    gap = -1;
    if (tb0 > ta1) gap = tb0 - ta1;
    else if (tb1 < ta0) gap = ta0 - tb1;
    if (gap < 0) begin
      o.joinable = 1'b1; o.verdict = VERDICT_OVERLAP;
    end else if (gap <= (longint'(gap_limit) << UNIT_BITS)) begin
      o.joinable = 1'b1; o.verdict = VERDICT_WITHIN_GAP;
    end else begin
      o.verdict = VERDICT_GAP_LARGE;
    end
    return o;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %0s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
    fails++;
  endtask

  task automatic send_pair(seg_word_t w);
    int n;
    seg_valid <= 1'b1;
    seg_word <= w;
    do @(posedge clk); while (seg_stall);
    verdicts_due = {verdicts_due, judge_pair(w)};
    n = idle_len();
    if (n > 0) begin
      seg_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic settle();
    seg_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_MAX_PLANE_DISTANCE) plane_limit = val;
    else gap_limit = val[13:0];
  endtask

  function automatic seg_word_t pair_of(bit md, int ax, int ay, int bx, int by,
                                        int cx, int cy, int dx, int dy,
                                        int w0 = 0, int w1 = 0);
    seg_word_t w;
    w.mode = md;
    w.first_start_x = COORD_BITS'(ax); w.first_start_y = COORD_BITS'(ay);
    w.first_end_x = COORD_BITS'(bx); w.first_end_y = COORD_BITS'(by);
    w.first_width = WIDTH_BITS'(w0);
    w.second_start_x = COORD_BITS'(cx); w.second_start_y = COORD_BITS'(cy);
    w.second_end_x = COORD_BITS'(dx); w.second_end_y = COORD_BITS'(dy);
    w.second_width = WIDTH_BITS'(w1);
    return w;
  endfunction

  function automatic seg_word_t chain_pair();
    int px, py, dx, dy, k1, t, k2, jx, jy;
    seg_word_t w;
    px = $urandom_range(0, 16383); py = $urandom_range(0, 16383);
    do begin
      dx = $urandom_range(0, 80) - 40; dy = $urandom_range(0, 80) - 40;
    end while (dx == 0 && dy == 0);
    k1 = $urandom_range(1, 50); t = $urandom_range(0, 180) - 60; k2 = $urandom_range(1, 50);
    jx = $urandom_range(0, 4) - 2; jy = $urandom_range(0, 4) - 2;
    w = seg_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    w.first_start_x = COORD_BITS'(px); w.first_start_y = COORD_BITS'(py);
    w.first_end_x = COORD_BITS'(px + dx * k1); w.first_end_y = COORD_BITS'(py + dy * k1);
    w.second_start_x = COORD_BITS'(px + dx * t + jx);
    w.second_start_y = COORD_BITS'(py + dy * t + jy);
    if ($urandom_range(0, 1)) begin
      w.second_end_x = COORD_BITS'(px + dx * (t + k2));
      w.second_end_y = COORD_BITS'(py + dy * (t + k2));
    end else begin
      w.second_end_x = w.second_start_x; w.second_end_y = w.second_start_y;
      w.second_start_x = COORD_BITS'(px + dx * (t + k2) - jy);
      w.second_start_y = COORD_BITS'(py + dy * (t + k2) + jx);
    end
    if ($urandom_range(0, 3) == 0) begin
      w.first_width = WIDTH_BITS'($urandom_range(0, 64));
      w.second_width = WIDTH_BITS'($urandom_range(0, 64));
    end
    return w;
  endfunction

  task automatic test_degenerate();
    send_pair(pair_of(0, 5, 5, 5, 5, 0, 0, 10, 0));
    send_pair(pair_of(1, 0, 0, 10, 0, 16383, 16383, 16383, 16383, 65535, 65535));
    send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_joins();
    send_pair(pair_of(0, 100, 100, 110, 100, 105, 100, 130, 100));
    send_pair(pair_of(0, 100, 100, 110, 100, 120, 100, 130, 100));
    send_pair(pair_of(0, 100, 100, 110, 100, 121, 100, 130, 100));
    send_pair(pair_of(0, 100, 100, 110, 100, 130, 100, 121, 100));
    send_pair(pair_of(0, 0, 0, 16383, 16383, 16383, 16383, 0, 0));
    send_pair(pair_of(0, 16383, 0, 0, 16383, 0, 16383, 16383, 0));
  endtask

  task automatic test_distance();
    send_pair(pair_of(0, 100, 100, 110, 100, 112, 102, 120, 102));
    send_pair(pair_of(0, 100, 100, 110, 100, 112, 103, 120, 103));
    send_pair(pair_of(0, 0, 0, 1, 0, 0, 16383, 16383, 16383));
    send_pair(pair_of(0, 0, 0, 0, 16383, 16383, 0, 16383, 16383));
  endtask

  task automatic test_width_mode();
    send_pair(pair_of(1, 100, 100, 110, 100, 112, 103, 120, 103, 48, 0));
    send_pair(pair_of(1, 100, 100, 110, 100, 112, 103, 120, 103, 0, 47));
    send_pair(pair_of(1, 100, 100, 110, 100, 105, 100, 120, 100, 0, 0));
    send_pair(pair_of(1, 0, 0, 1, 0, 0, 16383, 16383, 16383, 65535, 65535));
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(REG_MAX_PLANE_DISTANCE, 16'hFFFF);
    write_reg(REG_MAX_GAP, 16'h3FFF);
    send_pair(pair_of(0, 0, 0, 1, 0, 16383, 16383, 16383, 16383 - 1));
    send_pair(pair_of(0, 0, 0, 0, 1, 0, 16383, 0, 16382));
    settle();
    write_reg(REG_MAX_PLANE_DISTANCE, 16'd0);
    write_reg(REG_MAX_GAP, 16'd0);
    send_pair(pair_of(0, 100, 100, 110, 100, 110, 100, 130, 100));
    send_pair(pair_of(0, 100, 100, 110, 100, 111, 100, 130, 100));
    send_pair(pair_of(0, 100, 100, 110, 100, 111, 101, 130, 100));
  endtask

  task automatic test_random();
    int r;
    seg_word_t w;
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: begin
          write_reg(REG_MAX_PLANE_DISTANCE, 16'd32); write_reg(REG_MAX_GAP, 16'd10);
        end
        1: begin
          write_reg(REG_MAX_PLANE_DISTANCE, 16'd0); write_reg(REG_MAX_GAP, 16'd0);
        end
        2: begin
          write_reg(REG_MAX_PLANE_DISTANCE, 16'hFFFF); write_reg(REG_MAX_GAP, 16'h3FFF);
        end
        default: begin
          write_reg(REG_MAX_PLANE_DISTANCE, 16'($urandom_range(0, 96)));
          write_reg(REG_MAX_GAP, 16'($urandom_range(0, 60)));
        end
      endcase
      quiet = (phase == 3);
      for (int i = 0; i < 300; i++) begin
        r = $urandom_range(0, 99);
        if (r < 65) w = chain_pair();
        else if (r < 93) begin
          w = seg_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        end else begin
          w = chain_pair();
          w.second_end_x = w.second_start_x; w.second_end_y = w.second_start_y;
        end
        send_pair(w);
      end
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("segment_pair_connect_test_top test failed");
      $finish;
    end
  end

  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 3) == 0);
      default: res_stall <= ($urandom_range(0, 49) < 3) || ($urandom_range(0, 9) > 6);
    endcase
  end

  always @(posedge clk) begin
    res_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (verdicts_due.size() == 0) begin
        $display("unexpected result word at cycle %0d", cycles);
        fails++;
      end else begin
        want = verdicts_due.pop_front();
        if (res_word.joinable !== want.joinable)
          report_mismatch("joinable", res_word.joinable, want.joinable);
        if (res_word.verdict !== want.verdict)
          report_mismatch("verdict", res_word.verdict, want.verdict);
        if (res_word.line_distance !== want.line_distance)
          report_mismatch("line_distance", res_word.line_distance, want.line_distance);
      end
    end
  end

  initial begin
    plane_limit = MAX_PLANE_DISTANCE_RESET;
    gap_limit = MAX_GAP_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_degenerate();
    test_joins();
    test_distance();
    test_width_mode();
    test_register_extremes();
    test_random();
    settle();
    if (fails == 0) $display("segment_pair_connect_test_top test passed");
    else $display("segment_pair_connect_test_top test failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/scpt_pkg.sv
rtl/core/scpt_root.sv
rtl/core/scpt_delay.sv
rtl/core/segment_pair_connect_test_top.sv
tb/segment_pair_connect_test_top_test.sv
